// ===== rtl/core/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

    // Default size of the hue circle
    localparam int HUE_FULL_CIRCLE_DEF = 360;

    // Channel and field widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;

    // Saturation numerator: delta * 255
    localparam int SAT_NUM_W = 16;
    localparam int SAT_SCALE = 255;

    // Quotient bits, one divider stage each (covers both dividers)
    localparam int QUO_W = 8;

    // Channel that holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_convert.sv =====
`default_nettype none

// RGB to HSV pixel converter. One pixel is taken at each clock edge where
// start is high; busy never rises, so a pixel can enter every cycle. Each
// result sits on o_hsv for exactly one cycle with o_strobe high, in input
// order. The pipeline holds two stages of max/min and operand setup, eight
// restoring-divider stages (one quotient bit each, hue and saturation
// dividers side by side) and one output stage. The receiver cannot stall:
// results must be taken as shown.
module rgb_to_hsv_convert #(
    parameter int HUE_FULL_CIRCLE = rgbhsv_pkg::HUE_FULL_CIRCLE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rgbhsv_pkg::t_rgb i_pixel,
    output logic                  o_strobe,
    output rgbhsv_pkg::t_hsv      o_hsv
);
    import rgbhsv_pkg::*;

    localparam int SECTOR = (HUE_FULL_CIRCLE + 5) / 6;
    localparam int HNW    = $clog2(255 * SECTOR + 1);
    localparam int HXW    = HNW + CHAN_W;
    localparam int SXW    = SAT_NUM_W + CHAN_W;
    localparam int HSW    = HUE_W + 2;

    // Never hold off the source
    assign busy = 1'b0;

    // ---------------- Stage A: max, min, delta, sector ----------------
    logic              r_a_valid;
    logic [CHAN_W-1:0] r_a_hi;
    logic [CHAN_W-1:0] r_a_delta;
    t_sector           r_a_sec;
    t_rgb              r_a_pix;

    logic [CHAN_W-1:0] n_a_hi;
    logic [CHAN_W-1:0] n_a_lo;
    t_sector           n_a_sec;

    // Find extremes; red wins ties, then green
    always_comb begin
        n_a_hi  = i_pixel.red;
        n_a_lo  = i_pixel.red;
        if (i_pixel.green > n_a_hi) n_a_hi = i_pixel.green;
        if (i_pixel.blue  > n_a_hi) n_a_hi = i_pixel.blue;
        if (i_pixel.green < n_a_lo) n_a_lo = i_pixel.green;
        if (i_pixel.blue  < n_a_lo) n_a_lo = i_pixel.blue;
        if (i_pixel.red == n_a_hi) begin
            n_a_sec = SEC_RED;
        end else if (i_pixel.green == n_a_hi) begin
            n_a_sec = SEC_GREEN;
        end else begin
            n_a_sec = SEC_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start;
        end
        r_a_hi    <= n_a_hi;
        r_a_delta <= n_a_hi - n_a_lo;
        r_a_sec   <= n_a_sec;
        r_a_pix   <= i_pixel;
    end

    // ---------------- Stage B: operands for both dividers ----------------
    logic                 r_v    [QUO_W+1];
    logic [HNW-1:0]       r_hrem [QUO_W+1];
    logic [CHAN_W-1:0]    r_hden [QUO_W+1];
    logic [QUO_W-1:0]     r_hq   [QUO_W+1];
    logic [SAT_NUM_W-1:0] r_srem [QUO_W+1];
    logic [CHAN_W-1:0]    r_sden [QUO_W+1];
    logic [QUO_W-1:0]     r_sq   [QUO_W+1];
    logic [HUE_W-1:0]     r_base [QUO_W+1];
    logic                 r_neg  [QUO_W+1];
    logic [CHAN_W-1:0]    r_hi   [QUO_W+1];

    logic signed [CHAN_W:0] n_b_diff;
    logic [CHAN_W-1:0]      n_b_mag;
    logic [HUE_W-1:0]       n_b_base;

    // Pick channel difference and sector start
    always_comb begin
        case (r_a_sec)
            SEC_RED: begin
                n_b_diff = $signed({1'b0, r_a_pix.green}) - $signed({1'b0, r_a_pix.blue});
                n_b_base = '0;
            end
            SEC_GREEN: begin
                n_b_diff = $signed({1'b0, r_a_pix.blue}) - $signed({1'b0, r_a_pix.red});
                n_b_base = HUE_W'(2 * SECTOR);
            end
            default: begin
                n_b_diff = $signed({1'b0, r_a_pix.red}) - $signed({1'b0, r_a_pix.green});
                n_b_base = HUE_W'(4 * SECTOR);
            end
        endcase
        n_b_mag = n_b_diff[CHAN_W] ? CHAN_W'(-n_b_diff) : n_b_diff[CHAN_W-1:0];
    end

    // Load operands; a zero divisor becomes one over a zero numerator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_a_valid;
        end
        if (r_a_delta == '0) begin
            r_hrem[0] <= '0;
            r_hden[0] <= CHAN_W'(1);
            r_base[0] <= '0;
            r_neg[0]  <= 1'b0;
        end else begin
            r_hrem[0] <= HNW'(n_b_mag * SECTOR);
            r_hden[0] <= r_a_delta;
            r_base[0] <= n_b_base;
            r_neg[0]  <= n_b_diff[CHAN_W];
        end
        if (r_a_hi == '0) begin
            r_srem[0] <= '0;
            r_sden[0] <= CHAN_W'(1);
        end else begin
            r_srem[0] <= SAT_NUM_W'(r_a_delta * SAT_SCALE);
            r_sden[0] <= r_a_hi;
        end
        r_hq[0] <= '0;
        r_sq[0] <= '0;
        r_hi[0] <= r_a_hi;
    end

    // ---------------- Divider stages: one quotient bit each ----------------
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int J = QUO_W - 1 - k;

        logic [HXW-1:0] n_hsh;
        logic [SXW-1:0] n_ssh;
        logic           n_hge;
        logic           n_sge;

        // Trial subtract of the shifted divisor
        assign n_hsh = HXW'(r_hden[k]) << J;
        assign n_ssh = SXW'(r_sden[k]) << J;
        assign n_hge = HXW'(r_hrem[k]) >= n_hsh;
        assign n_sge = SXW'(r_srem[k]) >= n_ssh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_hrem[k+1] <= n_hge ? HNW'(HXW'(r_hrem[k]) - n_hsh) : r_hrem[k];
            r_srem[k+1] <= n_sge ? SAT_NUM_W'(SXW'(r_srem[k]) - n_ssh) : r_srem[k];
            r_hq[k+1]   <= r_hq[k] | (QUO_W'(n_hge) << J);
            r_sq[k+1]   <= r_sq[k] | (QUO_W'(n_sge) << J);
            r_hden[k+1] <= r_hden[k];
            r_sden[k+1] <= r_sden[k];
            r_base[k+1] <= r_base[k];
            r_neg[k+1]  <= r_neg[k];
            r_hi[k+1]   <= r_hi[k];
        end
    end

    // ---------------- Output stage: sign, offset, wrap ----------------
    logic signed [HSW-1:0] n_o_q;
    logic signed [HSW-1:0] n_o_hue;

    always_comb begin
        n_o_q   = $signed({{(HSW-QUO_W){1'b0}}, r_hq[QUO_W]});
        n_o_hue = $signed({2'b00, r_base[QUO_W]}) + (r_neg[QUO_W] ? -n_o_q : n_o_q);
        if (n_o_hue < 0) begin
            n_o_hue = n_o_hue + HSW'(HUE_FULL_CIRCLE);
        end
    end

    // Present each item for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_v[QUO_W];
        end
        o_hsv.hue        <= n_o_hue[HUE_W-1:0];
        o_hsv.saturation <= r_sq[QUO_W][CHAN_W-1:0];
        o_hsv.brightness <= r_hi[QUO_W];
    end

endmodule

`default_nettype wire

// ===== verif/rgb_to_hsv_convert_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_hsv_convert_tb;
    import rgbhsv_pkg::*;

    // Hue circle and sector size of the instance (default parameter)
    localparam int HUE_CIRCLE   = HUE_FULL_CIRCLE_DEF;
    localparam int HUE_SECTOR   = (HUE_CIRCLE + 5) / 6;
    localparam int PIPE_LATENCY = 11;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 850;
    localparam int CALM_TAIL    = 120;

    typedef struct {
        t_rgb px;
        bit   drain;
    } t_pixel_item;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_rgb i_pixel;
    logic o_strobe;
    t_hsv o_hsv;

    t_pixel_item pixel_q[$];
    t_hsv        hsv_expect_q[$];

    logic pixel_taken;
    int   gap_left;
    bit   idle_mode;
    int   stall_cycles;
    int   pixels_sent;
    int   results_checked;
    int   error_count;
    int   grey_count;
    int   wrap_count;

    rgb_to_hsv_convert DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_strobe (o_strobe),
        .o_hsv    (o_hsv)
    );

    // Free-running clock, 8 ns period
    always #4 i_clk = ~i_clk;

    // Integer HSV of one pixel; division truncates toward zero
    function automatic t_hsv predict_hsv(t_rgb px);
        int   r, g, b;
        int   hi, lo, delta;
        int   sat, hue;
        t_hsv res;
        r   = px.red;
        g   = px.green;
        b   = px.blue;
        hi  = r;
        lo  = r;
        sat = 0;
        hue = 0;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        if (hi != 0) begin
            sat = (delta * SAT_SCALE) / hi;
            if (delta != 0) begin
                // red wins ties, then green
                if (r == hi) begin
                    hue = ((g - b) * HUE_SECTOR) / delta;
                end else if (g == hi) begin
                    hue = 2 * HUE_SECTOR + ((b - r) * HUE_SECTOR) / delta;
                end else begin
                    hue = 4 * HUE_SECTOR + ((r - g) * HUE_SECTOR) / delta;
                end
                if (hue < 0) hue += HUE_CIRCLE;
            end
        end
        res.hue        = HUE_W'(hue);
        res.saturation = CHAN_W'(sat);
        res.brightness = CHAN_W'(hi);
        return res;
    endfunction

    function automatic t_pixel_item make_item(int r, int g, int b, bit drain);
        t_pixel_item it;
        it.px.red   = CHAN_W'(r);
        it.px.green = CHAN_W'(g);
        it.px.blue  = CHAN_W'(b);
        it.drain    = drain;
        return it;
    endfunction

    // Random pixel, half of them shaped toward greys, ties and extremes
    function automatic t_pixel_item random_item(bit drain);
        logic [CHAN_W-1:0] c0, c1, c2;
        t_pixel_item       it;
        c0 = CHAN_W'($urandom);
        c1 = CHAN_W'($urandom);
        c2 = CHAN_W'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                c1 = c0;
                c2 = c0;
            end
            6: begin
                case ($urandom_range(0, 2))
                    0: c1 = c0;
                    1: c2 = c0;
                    default: c2 = c1;
                endcase
            end
            7: begin
                c0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                c1 = $urandom_range(0, 1) ? 8'hFF : c1;
            end
            8: begin
                c0 = CHAN_W'($urandom_range(0, 3));
                c1 = CHAN_W'($urandom_range(0, 3));
                c2 = CHAN_W'($urandom_range(0, 3));
            end
            9: begin
                c1 = c0 ^ CHAN_W'($urandom_range(0, 3));
                c2 = c0 ^ CHAN_W'($urandom_range(0, 3));
            end
            default: ;
        endcase
        // rotate so the shaped channels land on every color
        case ($urandom_range(0, 2))
            0: it = make_item(c0, c1, c2, drain);
            1: it = make_item(c2, c0, c1, drain);
            default: it = make_item(c1, c2, c0, drain);
        endcase
        return it;
    endfunction

    // Drive pixels at the falling edge; hold until taken
    always @(negedge i_clk) begin
        t_pixel_item next_item;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !pixel_taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pixel_q.size() == 0) begin
            start <= 1'b0;
        end else if (pixel_q[0].drain && hsv_expect_q.size() != 0) begin
            // wait for the pipeline to empty
            start <= 1'b0;
        end else if (pixel_q.size() > CALM_TAIL && idle_mode &&
                     $urandom_range(0, 2) == 0) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(1, 18) - 1;
        end else begin
            next_item = pixel_q.pop_front();
            start     <= 1'b1;
            i_pixel   <= next_item.px;
            if ($urandom_range(0, 39) == 0) idle_mode <= ~idle_mode;
        end
    end

    // Sample at the rising edge: record taken pixels, check results
    always @(posedge i_clk) begin
        t_hsv exp_hsv;
        pixel_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (hsv_expect_q.size() == 0) begin
                $error("result with no pixel pending: hue %0d sat %0d val %0d",
                       o_hsv.hue, o_hsv.saturation, o_hsv.brightness);
                error_count++;
            end else begin
                exp_hsv = hsv_expect_q.pop_front();
                results_checked++;
                if (o_hsv.hue !== exp_hsv.hue) begin
                    $error("hue mismatch: expected %0d, actual %0d",
                           exp_hsv.hue, o_hsv.hue);
                    error_count++;
                end
                if (o_hsv.saturation !== exp_hsv.saturation) begin
                    $error("saturation mismatch: expected %0d, actual %0d",
                           exp_hsv.saturation, o_hsv.saturation);
                    error_count++;
                end
                if (o_hsv.brightness !== exp_hsv.brightness) begin
                    $error("brightness mismatch: expected %0d, actual %0d",
                           exp_hsv.brightness, o_hsv.brightness);
                    error_count++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            hsv_expect_q.push_back(predict_hsv(i_pixel));
            pixels_sent++;
            if (i_pixel.red == i_pixel.green && i_pixel.green == i_pixel.blue)
                grey_count++;
            if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue &&
                i_pixel.blue > i_pixel.green &&
                ((int'(i_pixel.blue) - int'(i_pixel.green)) * HUE_SECTOR) >=
                (int'(i_pixel.red) - int'(i_pixel.green)))
                wrap_count++;
        end
    end

    // Stop a run in which nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no pixel or result moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_pixel         = '0;
        pixel_taken     = 1'b0;
        gap_left        = 0;
        idle_mode       = 1'b0;
        stall_cycles    = 0;
        pixels_sent     = 0;
        results_checked = 0;
        error_count     = 0;
        grey_count      = 0;
        wrap_count      = 0;

        // Directed pixels: black, white, greys, primaries, ties, hue wrap
        pixel_q.push_back(make_item(0, 0, 0, 1'b0));
        pixel_q.push_back(make_item(255, 255, 255, 1'b0));
        pixel_q.push_back(make_item(128, 128, 128, 1'b0));
        pixel_q.push_back(make_item(1, 1, 1, 1'b0));
        pixel_q.push_back(make_item(255, 0, 0, 1'b0));
        pixel_q.push_back(make_item(0, 255, 0, 1'b0));
        pixel_q.push_back(make_item(0, 0, 255, 1'b0));
        pixel_q.push_back(make_item(255, 255, 0, 1'b0));
        pixel_q.push_back(make_item(0, 255, 255, 1'b0));
        pixel_q.push_back(make_item(255, 0, 255, 1'b0));
        pixel_q.push_back(make_item(255, 0, 1, 1'b0));
        pixel_q.push_back(make_item(255, 0, 128, 1'b0));
        pixel_q.push_back(make_item(255, 0, 254, 1'b0));
        pixel_q.push_back(make_item(1, 0, 0, 1'b0));
        pixel_q.push_back(make_item(0, 1, 1, 1'b0));
        pixel_q.push_back(make_item(1, 1, 0, 1'b0));
        pixel_q.push_back(make_item(254, 255, 255, 1'b0));
        pixel_q.push_back(make_item(255, 254, 0, 1'b0));
        pixel_q.push_back(make_item(200, 100, 150, 1'b0));
        pixel_q.push_back(make_item(10, 20, 30, 1'b0));
        pixel_q.push_back(make_item(170, 85, 85, 1'b1));
        pixel_q.push_back(make_item(85, 170, 85, 1'b0));

        // Random pixels, draining the pipeline now and then
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pixel_q.push_back(random_item(n % 200 == 100));
        end

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for all pixels, then all results, then let the pipe settle
        while (pixel_q.size() != 0 || start) @(posedge i_clk);
        while (hsv_expect_q.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("converted %0d pixels and checked %0d results (%0d grey, %0d with hue wrap)",
                 pixels_sent, results_checked, grey_count, wrap_count);
        $display("directed black, white, primaries and ties, then random pixels with gaps");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
